// ===== sv/msm_pkg.sv =====
// ----------------------------------------------------------------------------
// msm_pkg: shared types and constants of the multi-pattern string matcher
// holds slot and pattern geometry, csr indexes, kind codes and byte folding
// ----------------------------------------------------------------------------
package msm_pkg;

   localparam int NUM_PATTERNS    = 4;
   localparam int MAX_PATTERN_LEN = 32;

   localparam int SLOT_W = $clog2(NUM_PATTERNS);
   localparam int POS_W  = $clog2(MAX_PATTERN_LEN);
   localparam int LEN_W  = 6;
   localparam int KIND_W = 3;
   localparam int CNT_W  = 3;
   localparam int SLEN_W = POS_W + 1;
   localparam int LEN_CAP = 2 * MAX_PATTERN_LEN - 1;

   // csr register indexes
   localparam logic [1:0] CSR_PATTERN_COUNT   = 2'd0;
   localparam logic [1:0] CSR_PATTERN_KINDS   = 2'd1;
   localparam logic [1:0] CSR_PATTERN_LENGTHS = 2'd2;

   // match kinds
   localparam logic [KIND_W-1:0] KIND_CONTAINS = 3'd0;
   localparam logic [KIND_W-1:0] KIND_PREFIX   = 3'd1;
   localparam logic [KIND_W-1:0] KIND_EXACT    = 3'd2;
   localparam logic [KIND_W-1:0] KIND_SUFFIX   = 3'd3;
   localparam logic [KIND_W-1:0] KIND_ALWAYS   = 3'd4;

   typedef logic [MAX_PATTERN_LEN-1:0][7:0]   win_vec_type;
   typedef logic [NUM_PATTERNS-1:0][LEN_W-1:0] len_vec_type;

   // broadcast control from the top level to every cell
   typedef struct packed {
      logic              shift;    // subject byte transfer
      logic              restart;  // last byte of a subject
      logic              wr_en;    // pattern byte transfer
      logic [SLOT_W-1:0] wr_slot;
      logic [POS_W-1:0]  wr_pos;
      logic [7:0]        data;     // folded byte
   } cell_ctrl_type;

   // per-slot verdicts of one cell
   typedef struct packed {
      logic [NUM_PATTERNS-1:0] tail_ok;
      logic [NUM_PATTERNS-1:0] pre_bad;
   } cell_flags_type;

   // ascii upper case to lower case
   function automatic logic [7:0] fold_byte(input logic [7:0] b);
      logic [7:0] r;
      r = b;
      if (b >= 8'h41 && b <= 8'h5A) begin
         r = b + 8'd32;
      end
      return r;
   endfunction

endpackage

// ===== sv/msm_cell.sv =====
// ----------------------------------------------------------------------------
// msm_cell: one byte position of the matcher
// holds a window byte, the pattern bytes of every slot at this position and
// the prefix token; compares against the aligned window for each slot
// ----------------------------------------------------------------------------
module msm_cell
   import msm_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic [POS_W-1:0] cell_pos,
   input  cell_ctrl_type    ctrl,
   input  logic [7:0]       win_in,
   input  logic             tok_in,
   input  win_vec_type      win_all,
   input  len_vec_type      lens,
   output logic [7:0]       win_out,
   output logic             tok_out,
   output cell_flags_type   flags
);

   logic [7:0]             win_ff;
   logic                   tok_ff;
   logic [NUM_PATTERNS-1:0][7:0] pat_ff;
   logic [SLEN_W-1:0]      pos_ext;

   assign pos_ext = {1'b0, cell_pos};
   assign win_out = win_ff;
   assign tok_out = tok_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         win_ff <= '0;
      end else if (ctrl.shift) begin
         win_ff <= win_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset || (ctrl.shift && ctrl.restart)) begin
         tok_ff <= (cell_pos == '0);
      end else if (ctrl.shift) begin
         tok_ff <= tok_in;
      end
   end

   always_ff @(posedge clock) begin
      for (int s = 0; s < NUM_PATTERNS; s++) begin
         if (ctrl.wr_en && ctrl.wr_pos == cell_pos && ctrl.wr_slot == SLOT_W'(s)) begin
            pat_ff[s] <= ctrl.data;
         end
      end
   end

   // cell p of slot s lines up with the window byte of age len-1-p
   always_comb begin
      logic [SLEN_W-1:0] diff;
      logic              in_pat;
      flags = '0;
      for (int s = 0; s < NUM_PATTERNS; s++) begin
         diff   = lens[s] - SLEN_W'(1) - pos_ext;
         in_pat = pos_ext < lens[s];
         flags.tail_ok[s] = !in_pat || (pat_ff[s] == win_all[diff[POS_W-1:0]]);
         flags.pre_bad[s] = tok_ff && in_pat && (pat_ff[s] != ctrl.data);
      end
   end

endmodule

// ===== sv/multi_pattern_string_match.sv =====
// ----------------------------------------------------------------------------
// multi_pattern_string_match: case-insensitive multi-pattern string matcher
// streams subject bytes through a row of byte cells and reports, on the last
// byte, the first slot whose contains/prefix/exact/suffix/always test passes
// ----------------------------------------------------------------------------
// result: registered, valid in the cycle after the last-byte transfer
// throughput: one byte per cycle, pattern writes and subject bytes alike, unless a
//    result waits on rsp_tready; the window compare across the cell row is combinational
// reset: synchronous, clears csr registers, subject state and result valid;
//    the pattern store is not cleared and must be written before use
module multi_pattern_string_match
   import msm_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   // configuration writes
   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [23:0] csr_wdata,
   // input stream
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,  // pattern_slot[1:0], char_position[6:2], data_byte[14:7]
   input  logic        req_tuser,  // mode: 0 pattern write, 1 subject byte
   input  logic        req_tlast,  // last_byte
   // result stream
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata   // matched[0], match_slot[2:1]
);

   // csr registers
   logic [CNT_W-1:0]              count_ff;
   logic [NUM_PATTERNS*KIND_W-1:0] kinds_ff;
   logic [NUM_PATTERNS*LEN_W-1:0]  lens_ff;

   // subject state
   logic [LEN_W-1:0]        slen_ff, slen_in;
   logic [NUM_PATTERNS-1:0] cfound_ff, cfound_in;
   logic [NUM_PATTERNS-1:0] pok_ff, pok_in;

   // result register
   logic              rsp_valid_ff;
   logic              matched_ff, matched_in;
   logic [SLOT_W-1:0] slot_ff, slot_in;

   // transfer decode
   logic          req_xfer, sub_xfer, last_xfer;
   logic [7:0]    byte_folded;
   cell_ctrl_type ctrl;

   // cell row
   win_vec_type                       win_cur;
   logic [MAX_PATTERN_LEN-1:0][7:0]   cell_win;
   logic [MAX_PATTERN_LEN-1:0]        cell_tok;
   cell_flags_type [MAX_PATTERN_LEN-1:0] cell_flags;
   len_vec_type                       lens;

   // per-slot verdicts
   logic [NUM_PATTERNS-1:0] tail_hit, pre_bad, len_ok;
   logic [CNT_W-1:0]        count_eff;

   // result register parts the two channels; a free or draining slot lets
   // the next byte in
   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign req_xfer   = req_tvalid && req_tready;
   assign sub_xfer   = req_xfer && req_tuser;
   assign last_xfer  = sub_xfer && req_tlast;

   assign byte_folded = fold_byte(req_tdata[14:7]);

   always_comb begin
      ctrl.shift   = sub_xfer;
      ctrl.restart = req_tlast;
      ctrl.wr_en   = req_xfer && !req_tuser;
      ctrl.wr_slot = req_tdata[1:0];
      ctrl.wr_pos  = req_tdata[6:2];
      ctrl.data    = byte_folded;
   end

   always_comb begin
      for (int s = 0; s < NUM_PATTERNS; s++) begin
         lens[s] = lens_ff[s*LEN_W +: LEN_W];
      end
   end

   // window as it stands after this byte: new byte at age zero, the rest
   // handed down one cell
   always_comb begin
      win_cur[0] = byte_folded;
      for (int k = 1; k < MAX_PATTERN_LEN; k++) begin
         win_cur[k] = cell_win[k-1];
      end
   end

   for (genvar p = 0; p < MAX_PATTERN_LEN; p++) begin : g_cell
      logic tok_from;
      if (p == 0) begin : g_head
         assign tok_from = 1'b0;
      end else begin : g_body
         assign tok_from = cell_tok[p-1];
      end
      msm_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .cell_pos (POS_W'(p)),
         .ctrl     (ctrl),
         .win_in   (win_cur[p]),
         .tok_in   (tok_from),
         .win_all  (win_cur),
         .lens     (lens),
         .win_out  (cell_win[p]),
         .tok_out  (cell_tok[p]),
         .flags    (cell_flags[p])
      );
   end

   // saturating subject length including this byte
   assign slen_in = (slen_ff == LEN_W'(LEN_CAP)) ? slen_ff : slen_ff + LEN_W'(1);

   // gather cell verdicts per slot
   always_comb begin
      logic all_ok;
      for (int s = 0; s < NUM_PATTERNS; s++) begin
         len_ok[s]  = lens[s] >= LEN_W'(1) && lens[s] <= LEN_W'(MAX_PATTERN_LEN);
         all_ok     = 1'b1;
         pre_bad[s] = 1'b0;
         for (int p = 0; p < MAX_PATTERN_LEN; p++) begin
            all_ok     = all_ok & cell_flags[p].tail_ok[s];
            pre_bad[s] = pre_bad[s] | cell_flags[p].pre_bad[s];
         end
         // tail only counts once the subject is as long as the pattern
         tail_hit[s] = len_ok[s] && (slen_in >= lens[s]) && all_ok;
      end
   end

   assign cfound_in = cfound_ff | tail_hit;
   assign pok_in    = pok_ff & ~pre_bad;
   assign count_eff = (count_ff > CNT_W'(NUM_PATTERNS)) ? CNT_W'(NUM_PATTERNS) : count_ff;

   // kind test per slot, lowest passing slot wins
   always_comb begin
      logic ok;
      matched_in = 1'b0;
      slot_in    = '0;
      for (int s = NUM_PATTERNS - 1; s >= 0; s--) begin
         unique case (kinds_ff[s*KIND_W +: KIND_W])
            KIND_CONTAINS: ok = cfound_in[s];
            KIND_PREFIX:   ok = len_ok[s] && pok_in[s] && slen_in >= lens[s];
            KIND_EXACT:    ok = len_ok[s] && pok_in[s] && slen_in == lens[s];
            KIND_SUFFIX:   ok = tail_hit[s];
            KIND_ALWAYS:   ok = 1'b1;
            default:       ok = 1'b0;
         endcase
         if (ok && CNT_W'(s) < count_eff) begin
            matched_in = 1'b1;
            slot_in    = SLOT_W'(s);
         end
      end
   end

   // csr writes
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         kinds_ff <= '0;
         lens_ff  <= '0;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_PATTERN_COUNT:   count_ff <= csr_wdata[CNT_W-1:0];
            CSR_PATTERN_KINDS:   kinds_ff <= csr_wdata[NUM_PATTERNS*KIND_W-1:0];
            CSR_PATTERN_LENGTHS: lens_ff  <= csr_wdata[NUM_PATTERNS*LEN_W-1:0];
            default: ;
         endcase
      end
   end

   // subject state, back to reset values after the last byte
   always_ff @(posedge clock) begin
      if (reset || last_xfer) begin
         slen_ff   <= '0;
         cfound_ff <= '0;
         pok_ff    <= '1;
      end else if (sub_xfer) begin
         slen_ff   <= slen_in;
         cfound_ff <= cfound_in;
         pok_ff    <= pok_in;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (last_xfer) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (last_xfer) begin
         matched_ff <= matched_in;
         slot_ff    <= slot_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {5'b0, slot_ff, matched_ff};

   // subject state is back at its reset values after every last byte
   a_restart: assert property (@(posedge clock) disable iff (reset)
      last_xfer |=> (slen_ff == '0 && cfound_ff == '0 && pok_ff == '1))
      else $error("subject state not cleared after last byte");

   // no match reports slot zero
   a_slot_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !matched_ff) |-> (slot_ff == '0))
      else $error("slot set without a match");

   // a result only follows a last-byte transfer
   a_no_spurious: assert property (@(posedge clock) disable iff (reset)
      (!rsp_valid_ff && !last_xfer) |=> !rsp_valid_ff)
      else $error("result without a last byte");

   // prefix flags move only on subject bytes
   a_pok_hold: assert property (@(posedge clock) disable iff (reset)
      !sub_xfer |=> $stable(pok_ff))
      else $error("prefix flags changed without a subject byte");

   // at most one cell carries the prefix token
   a_token: assert property (@(posedge clock) disable iff (reset)
      $onehot0(cell_tok))
      else $error("more than one prefix token");

endmodule
